/* hw/rtl/i2p_pkg.sv */
// ----------------------------------------------------------------------------
// i2p_pkg
// Shared types, codes and defaults for the infix to postfix converter.
// ----------------------------------------------------------------------------
package i2p_pkg;

	// Default sizes
	localparam int STACK_DEPTH_DEF = 16;
	localparam int VALUE_WIDTH_DEF = 32;

	// Input token codes
	typedef enum logic [3:0] {
		OP_NUM   = 4'd0,
		OP_ADD   = 4'd1,
		OP_SUB   = 4'd2,
		OP_MUL   = 4'd3,
		OP_DIV   = 4'd4,
		OP_NEG   = 4'd5,
		OP_OPEN  = 4'd6,
		OP_CLOSE = 4'd7,
		OP_END   = 4'd8
	} opcode_t;

	// Output kinds that are not taken straight from the opcode
	localparam logic [2:0] KIND_NUM  = 3'd0;
	localparam logic [2:0] KIND_END  = 3'd6;
	// Stack entry that marks an open bracket
	localparam logic [2:0] OPEN_MARK = 3'd0;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_OVERFLOW = 2'd1,
		STAT_NO_OPEN  = 2'd2,
		STAT_NO_CLOSE = 2'd3
	} status_t;

	// Source of an emitted word
	typedef enum logic [1:0] {
		SEL_INPUT = 2'd0,
		SEL_TOP   = 2'd1,
		SEL_END   = 2'd2,
		SEL_ERR   = 2'd3
	} sel_t;

	// Sequencer states
	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic    load;
		logic    push;
		logic    pop;
		logic    clear;
		logic    emit;
		sel_t    sel;
		status_t status;
		logic    mark;
		logic    flush;
	} i2p_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		opcode_t    op;
		logic       postfix;
		logic       empty;
		logic       full;
		logic [2:0] top;
		logic       open_seen;
		logic       pend_valid;
		logic       out_free;
	} i2p_stat_t;

	// Operator priority: negate 2, multiply/divide 1, others 0
	function automatic logic [1:0] prio(input logic [2:0] kind);
		logic [1:0] p;
		p = 2'd0;
		if (kind == 3'(OP_NEG))
			p = 2'd2;
		else if (kind == 3'(OP_MUL) || kind == 3'(OP_DIV))
			p = 2'd1;
		return p;
	endfunction

endpackage

/* hw/rtl/i2p_if.sv */
// ----------------------------------------------------------------------------
// i2p channel interfaces
// Valid/ready channels for input tokens, output tokens and configuration.
// ----------------------------------------------------------------------------
interface i2p_tok_in_if #(
	parameter int VALUE_WIDTH = i2p_pkg::VALUE_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic [3:0]                    opcode;
	logic signed [VALUE_WIDTH-1:0] operand_value;

	modport source (output valid, output opcode, output operand_value, input ready);
	modport sink   (input valid, input opcode, input operand_value, output ready);
endinterface

interface i2p_tok_out_if #(
	parameter int VALUE_WIDTH = i2p_pkg::VALUE_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic [2:0]                    token_kind;
	logic signed [VALUE_WIDTH-1:0] token_value;
	logic                          last_of_run;
	logic [1:0]                    status;

	modport source (output valid, output token_kind, output token_value,
		output last_of_run, output status, input ready);
	modport sink   (input valid, input token_kind, input token_value,
		input last_of_run, input status, output ready);
endinterface

interface i2p_cfg_if;
	logic valid;
	logic ready;
	logic input_is_postfix;

	modport source (output valid, output input_is_postfix, input ready);
	modport sink   (input valid, input input_is_postfix, output ready);
endinterface

/* hw/rtl/infix_to_postfix_converter.sv */
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Reorders an infix token stream into postfix order with an operator stack.
// ----------------------------------------------------------------------------
// Usage:
//   tok_in carries one token per word (opcode, operand_value); tok_out
//   carries result words (token_kind, token_value, last_of_run, status);
//   cfg writes input_is_postfix and is always ready. Write cfg only while
//   no token is in flight.
//   A token is taken in the idle state and worked on from the next cycle;
//   each popped operator adds a further step, set by the single stack
//   read port, and no new token is taken until the last is done. A result
//   word passes the holding stage and then the output register. One word is
//   held back in a holding stage until the last_of_run flag is known.
//   When tok_out stalls, the holding stage fills and tok_in.ready drops
//   until the output drains; nothing is lost.
//   Reset clears the stack, the mode register (infix) and all valid flags.
//   The stack memory needs no clearing pass.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF,
	parameter int VALUE_WIDTH = i2p_pkg::VALUE_WIDTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	i2p_tok_in_if.sink    tok_in,
	i2p_tok_out_if.source tok_out,
	i2p_cfg_if.sink       cfg
);
	import i2p_pkg::*;

	i2p_cmd_t  cmd;
	i2p_stat_t stat;

	// Configuration writes are always taken
	assign cfg.ready = 1'b1;

	// Sequencer
	i2p_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (tok_in.valid),
		.in_ready (tok_in.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Stack and output datapath
	i2p_dp #(
		.STACK_DEPTH (STACK_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_opcode  (tok_in.opcode),
		.in_value   (tok_in.operand_value),
		.cfg_we     (cfg.valid),
		.cfg_data   (cfg.input_is_postfix),
		.out_ready  (tok_out.ready),
		.out_valid  (tok_out.valid),
		.out_kind   (tok_out.token_kind),
		.out_value  (tok_out.token_value),
		.out_last   (tok_out.last_of_run),
		.out_status (tok_out.status)
	);
endmodule

/* hw/rtl/i2p_ram.sv */
// ----------------------------------------------------------------------------
// i2p_ram
// Generic single write, single read RAM with registered, write-first read.
// ----------------------------------------------------------------------------
module i2p_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	// Registered read, new data on a same-address write
	always_ff @(posedge clk) begin
		if (we && waddr == raddr)
			rdata_q <= wdata;
		else
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

/* hw/rtl/i2p_ctrl.sv */
// ----------------------------------------------------------------------------
// i2p_ctrl
// Sequencer: takes a token, then one stack action per cycle when not stalled.
// ----------------------------------------------------------------------------
module i2p_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  i2p_pkg::i2p_stat_t stat,
	output i2p_pkg::i2p_cmd_t  cmd
);
	import i2p_pkg::*;

	state_t  state_q, state_d;
	logic    emit, push, pop, clr, mark, done, step_ok;
	sel_t    sel;
	status_t st;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// Decide the action for the current token
	always_comb begin
		emit = 1'b0;
		push = 1'b0;
		pop  = 1'b0;
		clr  = 1'b0;
		mark = 1'b0;
		done = 1'b0;
		sel  = SEL_INPUT;
		st   = STAT_OK;
		if (stat.postfix) begin
			done = 1'b1;
			if (stat.op inside {OP_NUM, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_NEG}) begin
				emit = 1'b1;
			end else if (stat.op == OP_END) begin
				emit = 1'b1;
				sel  = SEL_END;
			end
		end else begin
			case (stat.op)
				OP_NUM: begin
					emit = 1'b1;
					done = 1'b1;
				end
				OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_NEG: begin
					if (!stat.empty && stat.top != OPEN_MARK &&
						prio(stat.top) >= prio(stat.op[2:0])) begin
						pop  = 1'b1;
						emit = 1'b1;
						sel  = SEL_TOP;
					end else if (stat.full) begin
						clr  = 1'b1;
						emit = 1'b1;
						sel  = SEL_ERR;
						st   = STAT_OVERFLOW;
						done = 1'b1;
					end else begin
						push = 1'b1;
						done = 1'b1;
					end
				end
				OP_OPEN: begin
					done = 1'b1;
					if (stat.full) begin
						clr  = 1'b1;
						emit = 1'b1;
						sel  = SEL_ERR;
						st   = STAT_OVERFLOW;
					end else begin
						push = 1'b1;
					end
				end
				OP_CLOSE: begin
					if (stat.empty) begin
						emit = 1'b1;
						sel  = SEL_ERR;
						st   = STAT_NO_OPEN;
						done = 1'b1;
					end else if (stat.top == OPEN_MARK) begin
						pop  = 1'b1;
						done = 1'b1;
					end else begin
						pop  = 1'b1;
						emit = 1'b1;
						sel  = SEL_TOP;
					end
				end
				OP_END: begin
					if (stat.empty) begin
						emit = 1'b1;
						sel  = SEL_END;
						st   = stat.open_seen ? STAT_NO_CLOSE : STAT_OK;
						done = 1'b1;
					end else if (stat.top == OPEN_MARK) begin
						pop  = 1'b1;
						mark = 1'b1;
					end else begin
						pop  = 1'b1;
						emit = 1'b1;
						sel  = SEL_TOP;
					end
				end
				default: begin
					done = 1'b1;
				end
			endcase
		end
	end

	// An emit needs the holding stage free or drainable
	assign step_ok = !emit || !stat.pend_valid || stat.out_free;

	// Next state and commands
	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd.flush = stat.pend_valid && stat.out_free;
				in_ready  = !stat.pend_valid || stat.out_free;
				if (in_valid && in_ready) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (step_ok) begin
					cmd.push   = push;
					cmd.pop    = pop;
					cmd.clear  = clr;
					cmd.emit   = emit;
					cmd.sel    = sel;
					cmd.status = st;
					cmd.mark   = mark;
					if (done)
						state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	// A new token is taken only with the holding stage able to drain
	a_load_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!stat.pend_valid || cmd.flush))
		else $error("token taken while holding stage is blocked");
	// Stack actions happen only while a token is at work
	a_exec_only: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push || cmd.pop || cmd.emit) |-> state_q == S_EXEC)
		else $error("stack action outside execution");
	// An accepted token is processed on the next cycle
	a_load_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == S_EXEC)
		else $error("accepted token not executed");
`endif
endmodule

/* hw/rtl/i2p_dp.sv */
// ----------------------------------------------------------------------------
// i2p_dp
// Datapath: token registers, operator stack, holding stage and output word.
// ----------------------------------------------------------------------------
module i2p_dp #(
	parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF,
	parameter int VALUE_WIDTH = i2p_pkg::VALUE_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  i2p_pkg::i2p_cmd_t             cmd,
	output i2p_pkg::i2p_stat_t            stat,
	input  logic [3:0]                    in_opcode,
	input  logic signed [VALUE_WIDTH-1:0] in_value,
	input  logic                          cfg_we,
	input  logic                          cfg_data,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [2:0]                    out_kind,
	output logic signed [VALUE_WIDTH-1:0] out_value,
	output logic                          out_last,
	output logic [1:0]                    out_status
);
	import i2p_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	opcode_t                 op_q;
	logic [VALUE_WIDTH-1:0]  val_q;
	logic                    mode_q;
	logic                    open_seen_q;
	logic [CW-1:0]           count_q, count_d;
	logic [AW-1:0]           raddr;
	logic [2:0]              top;
	logic [2:0]              push_kind;
	logic                    out_free;
	logic                    out_load;

	logic                    pend_v_q;
	logic [2:0]              pend_kind_q;
	logic [VALUE_WIDTH-1:0]  pend_value_q;
	logic [1:0]              pend_status_q;
	logic [2:0]              emit_kind;
	logic [VALUE_WIDTH-1:0]  emit_value;

	logic                    out_valid_q;
	logic [2:0]              out_kind_q;
	logic [VALUE_WIDTH-1:0]  out_value_q;
	logic                    out_last_q;
	logic [1:0]              out_status_q;

	// Token registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= opcode_t'(in_opcode);
			val_q <= in_value;
		end
	end

	// Mode register, stack count and bracket flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			count_q     <= '0;
			open_seen_q <= 1'b0;
		end else begin
			if (cfg_we)
				mode_q <= cfg_data;
			count_q <= count_d;
			if (cmd.load)
				open_seen_q <= 1'b0;
			else if (cmd.mark)
				open_seen_q <= 1'b1;
		end
	end

	// Next stack count
	always_comb begin
		count_d = count_q;
		if (cmd.clear)
			count_d = '0;
		else if (cmd.pop)
			count_d = count_q - 1'b1;
		else if (cmd.push)
			count_d = count_q + 1'b1;
	end

	// Read the entry that will be on top next cycle
	assign raddr     = (count_d == '0) ? '0 : AW'(count_d - 1'b1);
	assign push_kind = (op_q == OP_OPEN) ? OPEN_MARK : op_q[2:0];

	i2p_ram #(
		.WIDTH (3),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (AW'(count_q)),
		.wdata (push_kind),
		.raddr (raddr),
		.rdata (top)
	);

	// Select the word to emit
	always_comb begin
		emit_kind  = KIND_NUM;
		emit_value = '0;
		case (cmd.sel)
			SEL_INPUT: begin
				emit_kind  = op_q[2:0];
				emit_value = (op_q == OP_NUM) ? val_q : '0;
			end
			SEL_TOP: begin
				emit_kind = top;
			end
			SEL_END: begin
				emit_kind = KIND_END;
			end
			default: begin
				emit_kind = KIND_NUM;
			end
		endcase
	end

	// Holding stage keeps one word back until the last flag is known
	assign out_free = !out_valid_q || out_ready;
	assign out_load = (cmd.emit && pend_v_q) || cmd.flush;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit)
				pend_v_q <= 1'b1;
			else if (cmd.flush)
				pend_v_q <= 1'b0;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Payload of holding stage and output word
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pend_kind_q   <= emit_kind;
			pend_value_q  <= emit_value;
			pend_status_q <= cmd.status;
		end
		if (out_load) begin
			out_kind_q   <= pend_kind_q;
			out_value_q  <= pend_value_q;
			out_status_q <= pend_status_q;
			out_last_q   <= cmd.flush;
		end
	end

	// Status toward the controller
	always_comb begin
		stat.op         = op_q;
		stat.postfix    = mode_q;
		stat.empty      = (count_q == '0);
		stat.full       = (count_q == CW'(STACK_DEPTH));
		stat.top        = top;
		stat.open_seen  = open_seen_q;
		stat.pend_valid = pend_v_q;
		stat.out_free   = out_free;
	end

	assign out_valid  = out_valid_q;
	assign out_kind   = out_kind_q;
	assign out_value  = out_value_q;
	assign out_last   = out_last_q;
	assign out_status = out_status_q;

`ifndef NO_ASSERTIONS
	// Stack count stays within the stack
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count out of range");
	// No push onto a full stack
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> count_q != CW'(STACK_DEPTH))
		else $error("push onto full stack");
	// No pop from an empty stack
	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> count_q != '0)
		else $error("pop from empty stack");
	// A word moves to the output only when the output can take it
	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (out_free && pend_v_q))
		else $error("output word overwritten");
`endif
endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for infix_to_postfix_converter. A clocked driver feeds
// token and mode words from a schedule. A clocked monitor checks every output
// word against a shunting-yard predictor, in order and field by field.
// ----------------------------------------------------------------------------
module testbench;
	import i2p_pkg::*;

	localparam int VW           = VALUE_WIDTH_DEF;
	localparam int DEPTH        = STACK_DEPTH_DEF;
	localparam int SETTLE_LIMIT = 32;
	localparam int STALL_LIMIT  = 4000;
	localparam int RANDOM_ITEMS = 140;

	typedef enum logic [1:0] {
		ACT_TOKEN = 2'd0,
		ACT_MODE  = 2'd1,
		ACT_DRAIN = 2'd2
	} action_t;

	typedef struct packed {
		action_t              act;
		logic [3:0]           op;
		logic signed [VW-1:0] val;
		logic                 mode;
	} sched_item_t;

	typedef struct packed {
		logic [2:0]           kind;
		logic signed [VW-1:0] value;
		logic                 last;
		status_t              status;
	} out_word_t;

	logic clk;
	logic arst_n;

	i2p_tok_in_if  #(.VALUE_WIDTH(VW)) tok_in_ch ();
	i2p_tok_out_if #(.VALUE_WIDTH(VW)) tok_out_ch ();
	i2p_cfg_if                         cfg_ch ();

	infix_to_postfix_converter #(
		.STACK_DEPTH(DEPTH),
		.VALUE_WIDTH(VW)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.tok_in  (tok_in_ch),
		.tok_out (tok_out_ch),
		.cfg     (cfg_ch)
	);

	// Schedule of pending words and the predicted output stream
	sched_item_t token_schedule[$];
	out_word_t   postfix_words[$];

	// Predictor state
	logic [2:0]  op_stack [DEPTH];
	int          stack_fill;
	logic        postfix_mode;

	// Planning and bookkeeping
	logic        plan_postfix;
	int          live_items;
	int          tokens_in;
	int          words_checked;
	int          mode_writes;
	int          overflow_seen;
	int          no_open_seen;
	int          no_close_seen;
	int          fail_count;
	int          settle;
	int          idle_cycles;

	// Clock
	always #6 clk = ~clk;

	function automatic int rank_of(input logic [2:0] kind);
		int r;
		r = 0;
		if (kind == 3'(OP_NEG))
			r = 2;
		else if (kind == 3'(OP_MUL) || kind == 3'(OP_DIV))
			r = 1;
		return r;
	endfunction

	task automatic add_word(input logic [2:0] kind, input logic signed [VW-1:0] value,
		input status_t status);
		out_word_t w;
		w.kind   = kind;
		w.value  = value;
		w.last   = 1'b0;
		w.status = status;
		postfix_words.push_back(w);
		if (status == STAT_OVERFLOW) overflow_seen++;
		if (status == STAT_NO_OPEN) no_open_seen++;
		if (status == STAT_NO_CLOSE) no_close_seen++;
	endtask

	// Predict the output words of one accepted token
	task automatic convert_token(input logic [3:0] op, input logic signed [VW-1:0] val);
		int         base;
		int         rank;
		logic [2:0] top;
		logic [2:0] entry;
		logic       done;
		status_t    end_status;
		base = postfix_words.size();
		if (op > OP_END) begin
			// undefined opcode: drop
		end else if (postfix_mode) begin
			if (op <= OP_NEG)
				add_word(op[2:0], (op == OP_NUM) ? val : '0, STAT_OK);
			else if (op == OP_END)
				add_word(KIND_END, '0, STAT_OK);
		end else begin
			case (op)
			OP_NUM: begin
				add_word(KIND_NUM, val, STAT_OK);
			end
			OP_CLOSE: begin
				// pop down to the matching open bracket
				done = 1'b0;
				while (stack_fill > 0 && !done) begin
					top = op_stack[stack_fill - 1];
					stack_fill--;
					if (top == OPEN_MARK)
						done = 1'b1;
					else
						add_word(top, '0, STAT_OK);
				end
				if (!done) add_word(KIND_NUM, '0, STAT_NO_OPEN);
			end
			OP_END: begin
				// flush everything, dropping leftover open brackets
				end_status = STAT_OK;
				while (stack_fill > 0) begin
					top = op_stack[stack_fill - 1];
					stack_fill--;
					if (top == OPEN_MARK)
						end_status = STAT_NO_CLOSE;
					else
						add_word(top, '0, STAT_OK);
				end
				add_word(KIND_END, '0, end_status);
			end
			default: begin
				// operators pop equal or higher rank first; open brackets just push
				entry = (op == OP_OPEN) ? OPEN_MARK : op[2:0];
				if (op != OP_OPEN) begin
					rank = rank_of(entry);
					done = 1'b0;
					while (stack_fill > 0 && !done) begin
						top = op_stack[stack_fill - 1];
						if (top == OPEN_MARK || rank_of(top) < rank) begin
							done = 1'b1;
						end else begin
							stack_fill--;
							add_word(top, '0, STAT_OK);
						end
					end
				end
				if (stack_fill >= DEPTH) begin
					stack_fill = 0;
					add_word(KIND_NUM, '0, STAT_OVERFLOW);
				end else begin
					op_stack[stack_fill] = entry;
					stack_fill++;
				end
			end
			endcase
		end
		if (postfix_words.size() > base)
			postfix_words[postfix_words.size() - 1].last = 1'b1;
	endtask

	function automatic logic signed [VW-1:0] pick_value();
		logic signed [VW-1:0] v;
		case ($urandom_range(7))
		0:       v = {1'b0, {(VW-1){1'b1}}};
		1:       v = {1'b1, {(VW-1){1'b0}}};
		2:       v = '0;
		3:       v = '1;
		4:       v = VW'($urandom_range(255));
		default: v = VW'($urandom);
		endcase
		return v;
	endfunction

	task automatic queue_token(input logic [3:0] op, input logic signed [VW-1:0] val);
		sched_item_t s;
		s.act  = ACT_TOKEN;
		s.op   = op;
		s.val  = val;
		s.mode = 1'b0;
		token_schedule.push_back(s);
		// count only tokens that do something
		if (op <= OP_END && !(plan_postfix && (op == OP_OPEN || op == OP_CLOSE)))
			live_items++;
	endtask

	task automatic hold_for_drain();
		sched_item_t s;
		s      = '0;
		s.act  = ACT_DRAIN;
		token_schedule.push_back(s);
	endtask

	task automatic set_mode(input logic mode);
		sched_item_t s;
		hold_for_drain();
		s      = '0;
		s.act  = ACT_MODE;
		s.mode = mode;
		token_schedule.push_back(s);
		plan_postfix = mode;
	endtask

	// Well-formed infix expression with random nesting, ended by an end token
	task automatic gen_expression();
		int   depth;
		int   terms;
		int   max_terms;
		int   r;
		logic want_operand;
		logic done;
		depth        = 0;
		terms        = 0;
		max_terms    = $urandom_range(1, 8);
		want_operand = 1'b1;
		done         = 1'b0;
		while (!done) begin
			r = $urandom_range(99);
			if (want_operand) begin
				if (r < 12) begin
					queue_token(OP_NEG, pick_value());
				end else if (r < 30 && depth < 7) begin
					queue_token(OP_OPEN, pick_value());
					depth++;
				end else begin
					queue_token(OP_NUM, pick_value());
					terms++;
					want_operand = 1'b0;
				end
			end else if (depth > 0 && (r < 25 || terms >= max_terms)) begin
				queue_token(OP_CLOSE, pick_value());
				depth--;
			end else if (terms >= max_terms) begin
				queue_token(OP_END, pick_value());
				done = 1'b1;
			end else begin
				queue_token(4'($urandom_range(OP_ADD, OP_DIV)), pick_value());
				want_operand = 1'b1;
			end
		end
	endtask

	task automatic add_random_infix();
		int n;
		if ($urandom_range(99) < 75) begin
			gen_expression();
		end else begin
			// noise: any opcode, broken brackets included
			n = $urandom_range(1, 3);
			repeat (n) queue_token(4'($urandom_range(15)), pick_value());
		end
	endtask

	// Driver: present scheduled words, hold them until taken
	always @(posedge clk) begin : driver
		logic                 nv;
		logic                 ncv;
		logic                 ncm;
		logic [3:0]           nop;
		logic signed [VW-1:0] nval;
		sched_item_t          head;
		nv   = 1'b0;
		ncv  = 1'b0;
		nop  = tok_in_ch.opcode;
		nval = tok_in_ch.operand_value;
		ncm  = cfg_ch.input_is_postfix;
		if (arst_n) begin
			if (tok_in_ch.valid && tok_in_ch.ready) begin
				convert_token(tok_in_ch.opcode, tok_in_ch.operand_value);
				void'(token_schedule.pop_front());
				tokens_in++;
			end else if (tok_in_ch.valid) begin
				nv = 1'b1;
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				postfix_mode = cfg_ch.input_is_postfix;
				void'(token_schedule.pop_front());
				mode_writes++;
			end else if (cfg_ch.valid) begin
				ncv = 1'b1;
			end
			if (!nv && !ncv && token_schedule.size() > 0) begin
				head = token_schedule[0];
				case (head.act)
				ACT_TOKEN: begin
					if ((tokens_in >= 100 && tokens_in < 170) || $urandom_range(99) >= 8) begin
						nv   = 1'b1;
						nop  = head.op;
						nval = head.val;
					end
				end
				ACT_MODE: begin
					ncv = 1'b1;
					ncm = head.mode;
				end
				default: begin
					// wait until every word is out, then let the pipe settle
					if (postfix_words.size() == 0) begin
						if (settle >= SETTLE_LIMIT) begin
							void'(token_schedule.pop_front());
							settle = 0;
						end else begin
							settle++;
						end
					end else begin
						settle = 0;
					end
				end
				endcase
			end
		end
		tok_in_ch.valid            <= nv;
		tok_in_ch.opcode           <= nop;
		tok_in_ch.operand_value    <= nval;
		cfg_ch.valid               <= ncv;
		cfg_ch.input_is_postfix    <= ncm;
	end

	// Monitor: check each output word, drive ready, track activity
	always @(posedge clk) begin : monitor
		logic      nr;
		out_word_t got;
		out_word_t want;
		nr = 1'b0;
		if (arst_n) begin
			if (tok_out_ch.valid && tok_out_ch.ready) begin
				got.kind   = tok_out_ch.token_kind;
				got.value  = tok_out_ch.token_value;
				got.last   = tok_out_ch.last_of_run;
				got.status = status_t'(tok_out_ch.status);
				if (postfix_words.size() == 0) begin
					$display("%0t: unexpected word kind=%0d value=%0d last=%0d status=%0d",
						$time, got.kind, got.value, got.last, got.status);
					fail_count++;
				end else begin
					want = postfix_words.pop_front();
					if (got.kind !== want.kind || got.value !== want.value ||
						got.last !== want.last || got.status !== want.status) begin
						$display("%0t: want k=%0d v=%0d l=%0d s=%0d got k=%0d v=%0d l=%0d s=%0d",
							$time, want.kind, want.value, want.last, want.status,
							got.kind, got.value, got.last, got.status);
						fail_count++;
					end
				end
				words_checked++;
			end
			if ((tok_in_ch.valid && tok_in_ch.ready) || (tok_out_ch.valid && tok_out_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			nr = (words_checked >= 120 && words_checked < 260) || $urandom_range(99) >= 8;
		end
		tok_out_ch.ready <= nr;
	end

	// Watchdog: give up when nothing moves for too long
	initial begin : watchdog
		wait (arst_n === 1'b1);
		while (idle_cycles < STALL_LIMIT) @(posedge clk);
		$display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : stimulus
		int base;
		clk                     = 1'b0;
		arst_n                  = 1'b0;
		tok_in_ch.valid         = 1'b0;
		tok_in_ch.opcode        = '0;
		tok_in_ch.operand_value = '0;
		cfg_ch.valid            = 1'b0;
		cfg_ch.input_is_postfix = 1'b0;
		tok_out_ch.ready        = 1'b0;
		stack_fill              = 0;
		postfix_mode            = 1'b0;
		plan_postfix            = 1'b0;
		live_items              = 0;
		tokens_in               = 0;
		words_checked           = 0;
		mode_writes             = 0;
		overflow_seen           = 0;
		no_open_seen            = 0;
		no_close_seen           = 0;
		fail_count              = 0;
		settle                  = 0;
		idle_cycles             = 0;

		// Directed: every operator, value extremes, brackets
		set_mode(1'b0);
		queue_token(OP_OPEN, '1);
		queue_token(OP_NUM, {1'b0, {(VW-1){1'b1}}});
		queue_token(OP_ADD, '0);
		queue_token(OP_NUM, {1'b1, {(VW-1){1'b0}}});
		queue_token(OP_CLOSE, '0);
		queue_token(OP_MUL, '1);
		queue_token(OP_NEG, '0);
		queue_token(OP_NUM, '0);
		queue_token(OP_SUB, '0);
		queue_token(OP_NUM, '1);
		queue_token(OP_DIV, '0);
		queue_token(OP_NUM, VW'(1));
		queue_token(OP_END, '1);
		// close bracket on an empty stack
		queue_token(OP_CLOSE, '0);
		// open bracket left over at the end
		queue_token(OP_OPEN, '0);
		queue_token(OP_END, '0);
		// push onto a full stack
		repeat (DEPTH) queue_token(OP_OPEN, '0);
		queue_token(OP_ADD, '0);
		// undefined opcodes
		queue_token(4'd9, '1);
		queue_token(4'd15, '1);

		// Directed pass-through
		set_mode(1'b1);
		queue_token(OP_NUM, {1'b1, {(VW-1){1'b0}}});
		queue_token(OP_NUM, {1'b0, {(VW-1){1'b1}}});
		queue_token(OP_ADD, '1);
		queue_token(OP_SUB, '0);
		queue_token(OP_MUL, '0);
		queue_token(OP_DIV, '0);
		queue_token(OP_NEG, '1);
		queue_token(OP_OPEN, '0);
		queue_token(OP_CLOSE, '0);
		queue_token(OP_END, '1);
		queue_token(4'd12, '1);
		set_mode(1'b0);

		// Random: mostly well-formed expressions, a pass-through stretch in between
		base = live_items;
		while (live_items < base + 55) add_random_infix();
		hold_for_drain();
		while (live_items < base + 95) add_random_infix();
		set_mode(1'b1);
		while (live_items < base + 120) queue_token(4'($urandom_range(15)), pick_value());
		set_mode(1'b0);
		while (live_items < base + RANDOM_ITEMS) add_random_infix();

		// Reset once
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Drain
		wait (token_schedule.size() == 0);
		wait (postfix_words.size() == 0);
		repeat (SETTLE_LIMIT) @(posedge clk);

		$display("Run: %0d tokens accepted, %0d output words checked, %0d mode writes.",
			tokens_in, words_checked, mode_writes);
		$display("Error words: %0d stack overflow, %0d unmatched close, %0d unmatched open.",
			overflow_seen, no_open_seen, no_close_seen);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
